@@ hw/rtl/entity_id_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// entity_id_allocator_core_defines
// assertion macros used by the allocator rtl (eia_ctrl)
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_CORE_DEFINES_SVH
`define ENTITY_ID_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define EIA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// check an implication on every clock edge outside reset
`define EIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// check a next-cycle implication outside reset
`define EIA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EIA_ASSERT(lbl, clk, rstn, prop)
`define EIA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EIA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/eia_pkg.sv @@
// ----------------------------------------------------------------------------
// eia_pkg
// constants, codes and memory port types of the identifier allocator
// ----------------------------------------------------------------------------
package eia_pkg;

    localparam int ID_CAPACITY  = 1024;
    localparam int SIG_BITS     = 32;
    localparam int ID_W         = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
    localparam int LIVE_W       = $clog2(ID_CAPACITY + 1);
    localparam int ENTITY_ID_W  = 16;
    localparam int RESULT_ID_W  = 10;
    localparam int SIG_IN_W     = 32;
    localparam int SIG_OUT_W    = 32;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE_LIVE = 2'd3;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic            re;
        logic [ID_W-1:0] raddr;
    } fq_req_t;

    typedef struct packed {
        logic                we;
        logic [ID_W-1:0]     waddr;
        logic [SIG_BITS-1:0] wdata;
        logic                re;
        logic [ID_W-1:0]     raddr;
    } sig_req_t;

    function automatic logic [ID_W-1:0] next_slot(input logic [ID_W-1:0] slot);
        return (slot == ID_W'(ID_CAPACITY - 1)) ? '0 : slot + 1'b1;
    endfunction

endpackage

@@ hw/rtl/eia_ram.sv @@
// ----------------------------------------------------------------------------
// eia_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module eia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/eia_ctrl.sv @@
// ----------------------------------------------------------------------------
// eia_ctrl
// request sequencer: clearing pass, read-modify-write of both stores,
// queue pointers, live count and result register
// ----------------------------------------------------------------------------
`include "entity_id_allocator_core_defines.svh"

module eia_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [eia_pkg::REQ_W-1:0]             s_req_type,
    input  logic [eia_pkg::ENTITY_ID_W-1:0]       s_entity_id,
    input  logic [eia_pkg::SIG_IN_W-1:0]          s_signature_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [eia_pkg::RESULT_ID_W-1:0]       m_result_id,
    output logic [eia_pkg::SIG_OUT_W-1:0]         m_signature_out,
    output logic [eia_pkg::STATUS_W-1:0]          m_status,
    output eia_pkg::fq_req_t                      fq_req,
    input  logic [eia_pkg::ID_W-1:0]              fq_rdata,
    output eia_pkg::sig_req_t                     sig_req,
    input  logic [eia_pkg::SIG_BITS-1:0]          sig_rdata
);

    import eia_pkg::*;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [ID_W-1:0]        init_idx_reg, init_idx_next;
    logic [ID_W-1:0]        head_reg, head_next;
    logic [ID_W-1:0]        tail_reg, tail_next;
    logic [LIVE_W-1:0]      live_reg, live_next;
    logic                   m_valid_reg, m_valid_next;

    logic [REQ_W-1:0]       req_type_reg;
    logic [ENTITY_ID_W-1:0] entity_id_reg;
    logic [SIG_IN_W-1:0]    signature_reg;
    logic [RESULT_ID_W-1:0] result_id_reg;
    logic [SIG_OUT_W-1:0]   signature_out_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic                   accept;
    logic                   commit;
    logic                   out_free;
    logic                   id_out_of_range;
    logic                   res_fq_push;
    logic                   res_sig_we;
    logic [SIG_BITS-1:0]    res_sig_wdata;
    logic [RESULT_ID_W-1:0] res_result_id;
    logic [SIG_OUT_W-1:0]   res_signature_out;
    logic [STATUS_W-1:0]    res_status;
    logic [ID_W-1:0]        res_head;
    logic [ID_W-1:0]        res_tail;
    logic [LIVE_W-1:0]      res_live;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_EXEC) && out_free;

    assign id_out_of_range =
        ({1'b0, entity_id_reg} >= (ENTITY_ID_W + 1)'(ID_CAPACITY));

    // outcome of the held request, using the data read at accept
    always_comb begin
        res_fq_push       = 1'b0;
        res_sig_we        = 1'b0;
        res_sig_wdata     = '0;
        res_result_id     = '0;
        res_signature_out = '0;
        res_status        = STATUS_OK;
        res_head          = head_reg;
        res_tail          = tail_reg;
        res_live          = live_reg;
        if (req_type_reg == REQ_ALLOC) begin
            if (live_reg == LIVE_W'(ID_CAPACITY)) begin
                res_status = STATUS_EMPTY;
            end else begin
                res_result_id = RESULT_ID_W'(fq_rdata);
                res_head      = next_slot(head_reg);
                res_live      = live_reg + 1'b1;
            end
        end else if (id_out_of_range) begin
            res_status = STATUS_RANGE;
        end else begin
            case (req_type_reg)
                REQ_RELEASE: begin
                    if (live_reg == '0) begin
                        res_status = STATUS_NONE_LIVE;
                    end else begin
                        res_sig_we  = 1'b1;
                        res_fq_push = 1'b1;
                        res_tail    = next_slot(tail_reg);
                        res_live    = live_reg - 1'b1;
                    end
                end
                REQ_SET: begin
                    res_sig_we    = 1'b1;
                    res_sig_wdata = SIG_BITS'(signature_reg);
                end
                default: begin
                    res_signature_out = SIG_OUT_W'(sig_rdata);
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        init_idx_next = init_idx_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        live_next     = live_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        fq_req        = '0;
        sig_req       = '0;
        case (state_reg)
            ST_INIT: begin
                // one slot a cycle: free list gets its index, signature gets zero
                fq_req.we     = 1'b1;
                fq_req.waddr  = init_idx_reg;
                fq_req.wdata  = init_idx_reg;
                sig_req.we    = 1'b1;
                sig_req.waddr = init_idx_reg;
                sig_req.wdata = '0;
                if (init_idx_reg == ID_W'(ID_CAPACITY - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    init_idx_next = init_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    fq_req.re     = 1'b1;
                    fq_req.raddr  = head_reg;
                    sig_req.re    = 1'b1;
                    sig_req.raddr = s_entity_id[ID_W-1:0];
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    fq_req.we     = res_fq_push;
                    fq_req.waddr  = tail_reg;
                    fq_req.wdata  = entity_id_reg[ID_W-1:0];
                    sig_req.we    = res_sig_we;
                    sig_req.waddr = entity_id_reg[ID_W-1:0];
                    sig_req.wdata = res_sig_wdata;
                    head_next     = res_head;
                    tail_next     = res_tail;
                    live_next     = res_live;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_idx_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            live_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            live_reg     <= live_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg  <= s_req_type;
            entity_id_reg <= s_entity_id;
            signature_reg <= s_signature_in;
        end
        if (commit) begin
            result_id_reg     <= res_result_id;
            signature_out_reg <= res_signature_out;
            status_reg        <= res_status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_id     = result_id_reg;
    assign m_signature_out = signature_out_reg;
    assign m_status        = status_reg;

    `EIA_ASSERT(a_live_bound, aclk, aresetn, live_reg <= LIVE_W'(ID_CAPACITY))
    `EIA_ASSERT_IMP(a_no_result_in_init, aclk, aresetn, state_reg == ST_INIT, !m_valid_reg)
    `EIA_ASSERT_NXT(a_alloc_counts, aclk, aresetn,
        commit && req_type_reg == REQ_ALLOC && res_status == STATUS_OK,
        live_reg == $past(live_reg) + 1'b1 && head_reg == next_slot($past(head_reg)))
    `EIA_ASSERT_NXT(a_error_no_change, aclk, aresetn,
        commit && res_status != STATUS_OK,
        $stable(live_reg) && $stable(head_reg) && $stable(tail_reg))

endmodule

@@ hw/rtl/entity_id_allocator_core.sv @@
// ----------------------------------------------------------------------------
// entity_id_allocator_core
// identifier allocator with a fifo free list and one signature word per id
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on the s_ channel (valid/ready), one beat per request:
//   allocate, release, set signature or get signature. each request gives
//   exactly one result beat on the m_ channel with result_id, signature_out
//   and status.
//   a request is accepted in the idle state, both stores are read at the
//   accepting edge, and the exec state registers the result once the output
//   register is free, which raises m_valid. no new request is taken until
//   the read-modify-write of the free-list ram and the signature ram is done.
//   the result sits in an output register; if the receiver stalls, the core
//   holds the finished result and one more request waits in the
//   sequencer until the output register frees up.
//   after reset a clearing pass over all ID_CAPACITY (1024) slots writes the
//   free list with ids in ascending order and zeroes every signature; s_ready
//   stays low until the pass ends.
// ----------------------------------------------------------------------------
module entity_id_allocator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [eia_pkg::REQ_W-1:0]             s_req_type,
    input  logic [eia_pkg::ENTITY_ID_W-1:0]       s_entity_id,
    input  logic [eia_pkg::SIG_IN_W-1:0]          s_signature_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [eia_pkg::RESULT_ID_W-1:0]       m_result_id,
    output logic [eia_pkg::SIG_OUT_W-1:0]         m_signature_out,
    output logic [eia_pkg::STATUS_W-1:0]          m_status
);

    import eia_pkg::*;

    fq_req_t             fq_req;
    sig_req_t            sig_req;
    logic [ID_W-1:0]     fq_rdata;
    logic [SIG_BITS-1:0] sig_rdata;

    eia_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_entity_id     (s_entity_id),
        .s_signature_in  (s_signature_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_id     (m_result_id),
        .m_signature_out (m_signature_out),
        .m_status        (m_status),
        .fq_req          (fq_req),
        .fq_rdata        (fq_rdata),
        .sig_req         (sig_req),
        .sig_rdata       (sig_rdata)
    );

    // free list: slot -> identifier
    eia_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_CAPACITY)
    ) u_free_queue (
        .aclk  (aclk),
        .we    (fq_req.we),
        .waddr (fq_req.waddr),
        .wdata (fq_req.wdata),
        .re    (fq_req.re),
        .raddr (fq_req.raddr),
        .rdata (fq_rdata)
    );

    // signature word per identifier
    eia_ram #(
        .WIDTH (SIG_BITS),
        .DEPTH (ID_CAPACITY)
    ) u_signature_store (
        .aclk  (aclk),
        .we    (sig_req.we),
        .waddr (sig_req.waddr),
        .wdata (sig_req.wdata),
        .re    (sig_req.re),
        .raddr (sig_req.raddr),
        .rdata (sig_rdata)
    );

endmodule

@@ dv/entity_id_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// entity_id_allocator_core_tb
// self-checking bench: a directed table, then random request traffic in
// phases with sender gaps, receiver stalls and a long receiver hold-off;
// every result beat is checked against a directed row's given result, else an in-bench model of the free list
// ----------------------------------------------------------------------------
module entity_id_allocator_core_tb;
    import eia_pkg::*;

    typedef struct packed {
        logic [RESULT_ID_W-1:0] rid;
        logic [SIG_OUT_W-1:0]   sig;
        logic [STATUS_W-1:0]    status;
    } alloc_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]       req;
        logic [ENTITY_ID_W-1:0] id;
        logic [SIG_IN_W-1:0]    sig;
        logic                   known;
        alloc_result_t          res;
    } request_row_t;

    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mix_t;

    localparam int N_DIRECTED      = 25;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_LIMIT     = 20000;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   s_valid         = 1'b0;
    logic [REQ_W-1:0]       s_req_type      = REQ_ALLOC;
    logic [ENTITY_ID_W-1:0] s_entity_id     = '0;
    logic [SIG_IN_W-1:0]    s_signature_in  = '0;
    logic                   m_ready         = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [RESULT_ID_W-1:0] m_result_id;
    logic [SIG_OUT_W-1:0]   m_signature_out;
    logic [STATUS_W-1:0]    m_status;

    // model of the allocator
    logic [ID_W-1:0]     free_ids [ID_CAPACITY];
    logic [SIG_BITS-1:0] sig_words [ID_CAPACITY];
    int                  head_slot;
    int                  tail_slot;
    int                  live_total;
    int                  live_ids[$];

    alloc_result_t pending_results[$];
    request_row_t  offered_rows[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;
    int            hold_left      = 0;
    bit            hold_pending   = 1'b0;

    request_row_t directed_rows [N_DIRECTED] = '{
        '{REQ_GET,     16'd0,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd1023,  32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_RELEASE, 16'd3,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_NONE_LIVE}},
        '{REQ_RELEASE, 16'd1024,  32'h0,        1'b1, '{10'd0, 32'h0, STATUS_RANGE}},
        '{REQ_SET,     16'd65535, 32'hFFFFFFFF, 1'b1, '{10'd0, 32'h0, STATUS_RANGE}},
        '{REQ_GET,     16'd1024,  32'h0,        1'b1, '{10'd0, 32'h0, STATUS_RANGE}},
        '{REQ_ALLOC,   16'd0,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_ALLOC,   16'd65535, 32'hFFFFFFFF, 1'b1, '{10'd1, 32'h0, STATUS_OK}},
        '{REQ_SET,     16'd0,     32'hFFFFFFFF, 1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd0,     32'h0,        1'b1, '{10'd0, 32'hFFFFFFFF, STATUS_OK}},
        '{REQ_SET,     16'd1023,  32'hA5A55A5A, 1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd1023,  32'hFFFFFFFF, 1'b1, '{10'd0, 32'hA5A55A5A, STATUS_OK}},
        '{REQ_SET,     16'd1,     32'h00000001, 1'b0, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_RELEASE, 16'd0,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd0,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        // id 0 released twice: not detected
        '{REQ_RELEASE, 16'd0,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_RELEASE, 16'd1,     32'h0,        1'b1, '{10'd0, 32'h0, STATUS_NONE_LIVE}},
        '{REQ_GET,     16'd1,     32'h0,        1'b0, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_ALLOC,   16'd0,     32'h0,        1'b1, '{10'd2, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd65535, 32'h0,        1'b1, '{10'd0, 32'h0, STATUS_RANGE}},
        '{REQ_RELEASE, 16'd1023,  32'h5A5A,     1'b1, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd1023,  32'h0,        1'b0, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_SET,     16'd512,   32'h80000000, 1'b0, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_ALLOC,   16'd0,     32'h0,        1'b0, '{10'd0, 32'h0, STATUS_OK}},
        '{REQ_GET,     16'd512,   32'h0,        1'b0, '{10'd0, 32'h0, STATUS_OK}}
    };

    entity_id_allocator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_entity_id     (s_entity_id),
        .s_signature_in  (s_signature_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_id     (m_result_id),
        .m_signature_out (m_signature_out),
        .m_status        (m_status)
    );

    always #6 aclk = ~aclk;

    // applies one accepted request to the model and returns its result
    function automatic alloc_result_t serve_request(input logic [REQ_W-1:0] req,
                                                    input logic [ENTITY_ID_W-1:0] id,
                                                    input logic [SIG_IN_W-1:0] sig);
        alloc_result_t res;
        res = '0;
        res.status = STATUS_OK;
        if (req == REQ_ALLOC) begin
            if (live_total >= ID_CAPACITY) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.rid = free_ids[head_slot];
                head_slot = (head_slot == ID_CAPACITY - 1) ? 0 : head_slot + 1;
                live_total++;
                live_ids.push_back(int'(res.rid));
            end
        end else if (id >= ID_CAPACITY) begin
            res.status = STATUS_RANGE;
        end else if (req == REQ_RELEASE) begin
            if (live_total == 0) begin
                res.status = STATUS_NONE_LIVE;
            end else begin
                sig_words[id] = '0;
                free_ids[tail_slot] = ID_W'(id);
                tail_slot = (tail_slot == ID_CAPACITY - 1) ? 0 : tail_slot + 1;
                live_total--;
                for (int k = 0; k < live_ids.size(); k++) begin
                    if (live_ids[k] == int'(id)) begin
                        live_ids.delete(k);
                        break;
                    end
                end
            end
        end else if (req == REQ_SET) begin
            sig_words[id] = sig[SIG_BITS-1:0];
        end else begin
            res.sig = sig_words[id];
        end
        return res;
    endfunction

    function automatic request_row_t make_request(input traffic_mix_t mix);
        request_row_t row;
        int           roll;
        int           id_roll;
        row = '0;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                row.req = (roll < 97) ? REQ_ALLOC : (roll < 99) ? REQ_SET : REQ_GET;
            end
            MIX_DRAIN: begin
                row.req = (roll < 80) ? REQ_RELEASE : (roll < 88) ? REQ_ALLOC :
                          (roll < 94) ? REQ_SET : REQ_GET;
            end
            default: begin
                row.req = (roll < 30) ? REQ_ALLOC : (roll < 55) ? REQ_RELEASE :
                          (roll < 80) ? REQ_SET : REQ_GET;
            end
        endcase
        // mostly ids that are live, some anywhere, a few out of range
        id_roll = $urandom_range(0, 99);
        if (id_roll < 6) begin
            row.id = ENTITY_ID_W'($urandom());
        end else if (id_roll < 9) begin
            case ($urandom_range(0, 3))
                0: row.id = '0;
                1: row.id = ENTITY_ID_W'(ID_CAPACITY - 1);
                2: row.id = ENTITY_ID_W'(ID_CAPACITY);
                default: row.id = '1;
            endcase
        end else if (id_roll < 20 || live_ids.size() == 0) begin
            row.id = ENTITY_ID_W'($urandom_range(0, ID_CAPACITY - 1));
        end else begin
            row.id = ENTITY_ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        end
        case ($urandom_range(0, 9))
            0: row.sig = '0;
            1: row.sig = '1;
            default: row.sig = $urandom();
        endcase
        row.known = 1'b0;
        return row;
    endfunction

    task automatic send_request(input request_row_t row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        offered_rows.push_back(row);
        s_valid        <= 1'b1;
        s_req_type     <= row.req;
        s_entity_id    <= row.id;
        s_signature_in <= row.sig;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: pending results expected 0 actual %0d",
                     $time, pending_results.size());
            mismatch_count++;
            pending_results.delete();
        end
    endtask

    task automatic run_phase(input traffic_mix_t mix, input int n_items,
                             input int idle_pct, input int stall, input bit hold);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        hold_pending  = hold;
        for (int i = 0; i < n_items; i++) begin
            send_request(make_request(mix));
        end
        s_valid <= 1'b0;
        wait_for_results();
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : scoreboard
        alloc_result_t predicted;
        alloc_result_t want;
        request_row_t  offered;
        if (aresetn && s_valid && s_ready) begin
            predicted = serve_request(s_req_type, s_entity_id, s_signature_in);
            offered = offered_rows.pop_front();
            pending_results.push_back(offered.known ? offered.res : predicted);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat expected none actual id %h sig %h status %h",
                         $time, m_result_id, m_signature_out, m_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_id !== want.rid) begin
                    $display("%0t: result_id expected %h actual %h",
                             $time, want.rid, m_result_id);
                    mismatch_count++;
                end
                if (m_signature_out !== want.sig) begin
                    $display("%0t: signature_out expected %h actual %h",
                             $time, want.sig, m_signature_out);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %h actual %h",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < ID_CAPACITY; i++) begin
            free_ids[i]  = ID_W'(i);
            sig_words[i] = '0;
        end
        head_slot  = 0;
        tail_slot  = 0;
        live_total = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // the clearing pass keeps s_ready low; the first beat just waits on it
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i]);
        end
        s_valid <= 1'b0;
        wait_for_results();

        run_phase(MIX_BALANCED, 150, 0, 0, 1'b0);
        run_phase(MIX_BALANCED, 120, 82, 0, 1'b0);
        run_phase(MIX_BALANCED, 120, 0, 82, 1'b0);
        // receiver holds off while the sender keeps offering beats
        run_phase(MIX_BALANCED, 40, 0, 0, 1'b1);
        // pushes the free list past wraparound and into the empty case
        run_phase(MIX_FILL, 1060, 13, 13, 1'b0);
        run_phase(MIX_DRAIN, 210, 0, 0, 1'b0);

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/eia_pkg.sv
hw/rtl/eia_ram.sv
hw/rtl/eia_ctrl.sv
hw/rtl/entity_id_allocator_core.sv
dv/entity_id_allocator_core_tb.sv
